FILE: design/deq_pkg.sv
// Package for the double-ended queue: sizes, operation and status codes,
// and the control struct that the top level hands to every storage cell.
// Depends on nothing.
package deq_pkg;

    // Storage sizes.
    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;

    // Widths of the channel fields and of the derived counters.
    localparam int VALUE_W = 32;
    localparam int POP_W   = 32;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int IDX_W   = $clog2(DEPTH);

    // Operation codes carried in the mode field.
    typedef enum logic [1:0] {
        MODE_PUSH_HEAD = 2'd0,
        MODE_PUSH_TAIL = 2'd1,
        MODE_POP_HEAD  = 2'd2,
        MODE_POP_TAIL  = 2'd3
    } t_mode;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_DONE       = 2'd0,
        ST_POP_EMPTY  = 2'd1,
        ST_PUSH_FULL  = 2'd2
    } t_status;

    // Per-cycle control broadcast to the row of cells.
    typedef struct packed {
        logic                  shift_in;   // push at head: every cell takes its left neighbor
        logic                  shift_out;  // pop at head: every cell takes its right neighbor
        logic                  load_tail;  // push at tail: the cell at wr_idx takes word
        logic [IDX_W-1:0]      wr_idx;     // first free slot
        logic [IDX_W-1:0]      rd_idx;     // last occupied slot
        logic [DATA_WIDTH-1:0] word;       // word being pushed
    } t_cell_ctl;

endpackage

FILE: design/deq_if.sv
// Valid/ready channel interfaces for the deque's operation and result beats.
// Depends on deq_pkg.
interface deq_in_if;
    import deq_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [1:0]                mode;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
endinterface

interface deq_out_if;
    import deq_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [POP_W-1:0] popped;
    logic [1:0]              status;
    logic [CNT_W-1:0]        count;
    logic                    is_empty;

    modport source (output valid, output popped, output status, output count,
                    output is_empty, input ready);
    modport sink   (input valid, input popped, input status, input count,
                    input is_empty, output ready);
endinterface

FILE: design/deq_cell.sv
// One storage cell of the deque's shift row. It holds one word and trades
// it with its neighbors on head pushes and pops. Depends on deq_pkg.
module deq_cell (
    input  logic                           i_clk,
    input  deq_pkg::t_cell_ctl             i_ctl,
    input  logic [deq_pkg::IDX_W-1:0]      i_index,
    input  logic [deq_pkg::DATA_WIDTH-1:0] i_left_data,
    input  logic [deq_pkg::DATA_WIDTH-1:0] i_right_data,
    input  logic [deq_pkg::DATA_WIDTH-1:0] i_tap,
    output logic [deq_pkg::DATA_WIDTH-1:0] o_data,
    output logic [deq_pkg::DATA_WIDTH-1:0] o_tap
);
    import deq_pkg::*;

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;

    // Next word: shift toward the tail, shift toward the head, or load at the tail.
    always_comb begin
        n_data = r_data;
        if (i_ctl.shift_in) begin
            n_data = i_left_data;
        end else if (i_ctl.shift_out) begin
            n_data = i_right_data;
        end else if (i_ctl.load_tail && (i_index == i_ctl.wr_idx)) begin
            n_data = i_ctl.word;
        end
    end

    // Payload register; no reset needed.
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    // The last occupied cell places its word on the tail read chain.
    assign o_tap  = (i_index == i_ctl.rd_idx) ? r_data : i_tap;
    assign o_data = r_data;

endmodule

FILE: design/double_ended_queue_top.sv
// Double-ended queue of signed words, held in a row of DEPTH shift cells
// with the head always in cell 0. Depends on deq_pkg, deq_if and deq_cell.
//
// Each operation beat (push head, push tail, pop head, pop tail) updates the
// whole row in a single step, so a new beat is accepted every cycle while
// the result side is taking beats. Exactly one result beat comes out per
// operation in the cycle after acceptance, held in an output register. A
// push onto a full queue is dropped with status 2, a pop from an empty queue
// is refused with status 1; neither changes state.
module double_ended_queue_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    deq_in_if.sink        i_in,
    deq_out_if.source     o_out
);
    import deq_pkg::*;

    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic                  r_out_valid;
    logic [POP_W-1:0]      r_popped;
    logic [POP_W-1:0]      n_popped;
    t_status               r_status;
    t_status               n_status;
    logic [CNT_W-1:0]      r_res_count;

    logic                  w_fire;
    logic                  w_full;
    logic                  w_empty;
    t_mode                 w_mode;
    t_cell_ctl             w_ctl;
    logic [CNT_W-1:0]      w_count_m1;
    logic [DATA_WIDTH-1:0] w_data [DEPTH];
    logic [DATA_WIDTH-1:0] w_tap  [DEPTH+1];

    // Input beat handshake: the output register frees as it is taken.
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_fire     = i_in.valid && i_in.ready;
    assign w_mode     = t_mode'(i_in.mode);
    assign w_full     = (r_count == CNT_W'(DEPTH));
    assign w_empty    = (r_count == '0);
    assign w_count_m1 = r_count - CNT_W'(1);

    // Decode the beat into cell controls, next count, result word and status.
    always_comb begin
        w_ctl.shift_in  = 1'b0;
        w_ctl.shift_out = 1'b0;
        w_ctl.load_tail = 1'b0;
        w_ctl.wr_idx    = r_count[IDX_W-1:0];
        w_ctl.rd_idx    = w_count_m1[IDX_W-1:0];
        w_ctl.word      = DATA_WIDTH'(i_in.value);
        n_count         = r_count;
        n_popped        = '0;
        n_status        = ST_DONE;
        case (w_mode)
            MODE_PUSH_HEAD, MODE_PUSH_TAIL: begin
                if (w_full) begin
                    n_status = ST_PUSH_FULL;
                end else begin
                    w_ctl.shift_in  = w_fire && (w_mode == MODE_PUSH_HEAD);
                    w_ctl.load_tail = w_fire && (w_mode == MODE_PUSH_TAIL);
                    n_count         = r_count + CNT_W'(1);
                end
            end
            MODE_POP_HEAD: begin
                if (w_empty) begin
                    n_status = ST_POP_EMPTY;
                end else begin
                    w_ctl.shift_out = w_fire;
                    n_popped        = POP_W'(w_data[0]);
                    n_count         = w_count_m1;
                end
            end
            MODE_POP_TAIL: begin
                if (w_empty) begin
                    n_status = ST_POP_EMPTY;
                end else begin
                    n_popped = POP_W'(w_tap[DEPTH]);
                    n_count  = w_count_m1;
                end
            end
            default: begin
                n_status = ST_DONE;
            end
        endcase
    end

    // Row of storage cells; the tail read chain runs from cell 0 upward.
    assign w_tap[0] = '0;
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_left;
        logic [DATA_WIDTH-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = w_ctl.word;
        end else begin : g_inner_l
            assign w_left = w_data[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_inner_r
            assign w_right = w_data[g+1];
        end
        deq_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_index      (IDX_W'(g)),
            .i_left_data  (w_left),
            .i_right_data (w_right),
            .i_tap        (w_tap[g]),
            .o_data       (w_data[g]),
            .o_tap        (w_tap[g+1])
        );
    end

    // Element count and result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_count <= n_count;
            end
            if (i_in.ready) begin
                r_out_valid <= w_fire;
            end
        end
    end

    // Result payload register.
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_popped    <= n_popped;
            r_status    <= n_status;
            r_res_count <= n_count;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.popped   = r_popped;
    assign o_out.status   = r_status;
    assign o_out.count    = r_res_count;
    assign o_out.is_empty = (r_res_count == '0);

endmodule

FILE: dv/deq_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the double-ended queue: watches both channels, predicts
// each result beat from its own ring model and compares. Depends on deq_pkg and deq_if.
module deq_result_checker
    import deq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    deq_in_if    op_ch,
    deq_out_if   res_ch,
    output int   o_fail_count,
    output int   o_pending
);

    // One expected result beat.
    typedef struct packed {
        logic signed [POP_W-1:0] popped;
        logic [1:0]              status;
        logic [CNT_W-1:0]        count;
        logic                    is_empty;
    } deq_result_t;

    // Shadow copy of the ring.
    logic signed [DATA_WIDTH-1:0] ring_slots [DEPTH];
    logic [IDX_W-1:0]             head_idx;
    logic [IDX_W-1:0]             tail_idx;
    logic [CNT_W-1:0]             held;

    deq_result_t expected_results [$];
    int          mismatches = 0;
    int          pending    = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = pending;

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    function automatic logic [IDX_W-1:0] ring_fwd(input logic [IDX_W-1:0] idx);
        return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] ring_back(input logic [IDX_W-1:0] idx);
        return (idx == '0) ? IDX_W'(DEPTH - 1) : idx - 1'b1;
    endfunction

    // Apply one operation to the shadow ring and form the result it yields.
    task automatic predict_deque_op(input t_mode op, input logic signed [DATA_WIDTH-1:0] word,
                                    output deq_result_t r);
        r.popped = '0;
        r.status = ST_DONE;
        case (op)
            MODE_PUSH_HEAD, MODE_PUSH_TAIL: begin
                if (held >= CNT_W'(DEPTH)) begin
                    r.status = ST_PUSH_FULL;
                end else if (op == MODE_PUSH_HEAD) begin
                    head_idx = ring_back(head_idx);
                    ring_slots[head_idx] = word;
                    held++;
                end else begin
                    ring_slots[tail_idx] = word;
                    tail_idx = ring_fwd(tail_idx);
                    held++;
                end
            end
            default: begin
                if (held == '0) begin
                    r.status = ST_POP_EMPTY;
                end else if (op == MODE_POP_HEAD) begin
                    r.popped = ring_slots[head_idx];
                    head_idx = ring_fwd(head_idx);
                    held--;
                end else begin
                    tail_idx = ring_back(tail_idx);
                    r.popped = ring_slots[tail_idx];
                    held--;
                end
            end
        endcase
        r.count    = held;
        r.is_empty = (held == '0);
    endtask

    // Compare one result beat against the oldest expectation.
    task automatic check_result(input deq_result_t got);
        deq_result_t want;
        if (expected_results.size() == 0) begin
            report_mismatch("result beat with no operation outstanding");
            return;
        end
        want = expected_results.pop_front();
        if (got.popped !== want.popped)
            report_mismatch($sformatf("popped %0d, expected %0d", got.popped, want.popped));
        if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
        if (got.count !== want.count)
            report_mismatch($sformatf("count %0d, expected %0d", got.count, want.count));
        if (got.is_empty !== want.is_empty)
            report_mismatch($sformatf("is_empty %0b, expected %0b",
                                      got.is_empty, want.is_empty));
    endtask

    // Sample both channels at the rising edge.
    always @(posedge i_clk) begin
        deq_result_t r;
        deq_result_t got;
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++)
                ring_slots[i] = '0;
            head_idx = '0;
            tail_idx = '0;
            held     = '0;
            expected_results.delete();
        end else begin
            if (op_ch.valid && op_ch.ready) begin
                predict_deque_op(t_mode'(op_ch.mode), op_ch.value[DATA_WIDTH-1:0], r);
                expected_results.push_back(r);
            end
            if (res_ch.valid && res_ch.ready) begin
                got.popped   = res_ch.popped;
                got.status   = res_ch.status;
                got.count    = res_ch.count;
                got.is_empty = res_ch.is_empty;
                check_result(got);
            end
        end
        pending = expected_results.size();
    end

endmodule

FILE: dv/tb_double_ended_queue_top.sv
`timescale 1ns / 1ps
// Testbench top for the double-ended queue: clock, reset, operation stimulus
// and result-side stalls. Depends on deq_pkg, deq_if, the block and deq_result_checker.
module tb_double_ended_queue_top;
    import deq_pkg::*;

    logic i_clk;
    logic i_rst_n;

    deq_in_if  in_ch();
    deq_out_if out_ch();

    int fail_count;
    int pending;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int rx_hold_req = 0;

    double_ended_queue_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    deq_result_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .op_ch        (in_ch),
        .res_ch       (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 10 ns clock.
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Hard limit on the run.
    initial begin
        #3_000_000;
        $display("Verification failed");
        $finish;
    end

    // Result side: random stalls, plus long hold-offs on request.
    initial begin : result_side
        int hold_left;
        hold_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req > 0) begin
                hold_left   = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Offer one operation beat and hold it until accepted; returns at a falling edge.
    task automatic send_op(input t_mode op, input logic signed [VALUE_W-1:0] word);
        in_ch.valid <= 1'b1;
        in_ch.mode  <= op;
        in_ch.value <= word;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    // Same, with a random gap in front of the beat: each cycle the sender
    // stays idle with the current idle percentage.
    task automatic send_op_gapped(input t_mode op, input logic signed [VALUE_W-1:0] word);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        send_op(op, word);
    endtask

    // Stop offering beats until every outstanding result has come back.
    task automatic wait_results_drained();
        in_ch.valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_word();
        case ($urandom_range(9))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return -1;
            default: return $urandom;
        endcase
    endfunction

    // Random operations in stretches that lean toward pushes or pops, so the
    // queue keeps swinging between empty and full and the positions wrap.
    task automatic run_random_ops(input int n_ops);
        int    seg_left;
        int    push_pct;
        t_mode op;
        seg_left = 0;
        push_pct = 50;
        for (int i = 0; i < n_ops; i++) begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(10, 60);
                case ($urandom_range(2))
                    0:       push_pct = 15;
                    1:       push_pct = 50;
                    default: push_pct = 85;
                endcase
            end
            seg_left--;
            if ($urandom_range(99) < push_pct)
                op = $urandom_range(1) ? MODE_PUSH_TAIL : MODE_PUSH_HEAD;
            else
                op = $urandom_range(1) ? MODE_POP_TAIL : MODE_POP_HEAD;
            send_op_gapped(op, pick_word());
        end
    endtask

    initial begin
        in_ch.valid <= 1'b0;
        in_ch.mode  <= MODE_PUSH_HEAD;
        in_ch.value <= '0;
        i_rst_n     <= 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: pops on empty, extreme words, head wrap below zero, then
        // fill to full with both ends and push twice more onto the full queue.
        send_op(MODE_POP_HEAD, 32'sd5);
        send_op(MODE_POP_TAIL, -32'sd5);
        send_op(MODE_PUSH_HEAD, 32'sh7FFF_FFFF);
        send_op(MODE_PUSH_TAIL, 32'sh8000_0000);
        send_op(MODE_POP_HEAD, '0);
        send_op(MODE_POP_TAIL, '0);
        send_op(MODE_PUSH_HEAD, -1);
        send_op(MODE_POP_TAIL, '0);
        for (int i = 0; i < DEPTH; i++)
            send_op((i % 2) ? MODE_PUSH_TAIL : MODE_PUSH_HEAD, $urandom);
        send_op(MODE_PUSH_HEAD, 32'sh1234_5678);
        send_op(MODE_PUSH_TAIL, -32'sh1234_5678);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct = 23;
                    rx_idle_pct = 54;
                end
                1: begin
                    tx_idle_pct = 54;
                    rx_idle_pct = 23;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            if (phase == 0) begin
                // Long result hold-off while pushes keep coming, so the block
                // backs up and stalls its input.
                in_ch.valid <= 1'b0;
                @(posedge i_clk);
                rx_hold_req = 90;
                @(negedge i_clk);
                for (int i = 0; i < 24; i++)
                    send_op($urandom_range(1) ? MODE_PUSH_TAIL : MODE_PUSH_HEAD, pick_word());
            end else if (phase == 1) begin
                wait_results_drained();
            end
            run_random_ops(440);
        end

        wait_results_drained();
        repeat (20) @(negedge i_clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: files.f
design/deq_pkg.sv
design/deq_if.sv
design/deq_cell.sv
design/double_ended_queue_top.sv
dv/deq_result_checker.sv
dv/tb_double_ended_queue_top.sv
